[rtl/assert_macros.svh]
// assertion macros shared by the deframer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cdf_pkg.sv]
// shared constants, types and the crc byte step for the frame deframer
// no dependencies; imported by every deframer module
`timescale 1ns / 1ps

package cdf_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int CRC_SPAN    = 4;
	localparam int FILL_W      = $clog2(FRAME_BYTES + 1);

	// window positions, oldest byte at position zero
	localparam int POS_START = 0;
	localparam int POS_LEFT  = 1;
	localparam int POS_RIGHT = 2;
	localparam int POS_FLAGS = 3;
	localparam int POS_CRC_H = 4;
	localparam int POS_CRC_L = 5;
	localparam int POS_END_H = 6;
	localparam int POS_END_L = 7;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0]  START_MARKER_RESET = 8'hDE;
	localparam logic [15:0] END_MARKER_RESET   = 16'h0D0A;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_MARKER = 1'b0,
		REG_END_MARKER   = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		FRAME_GOOD    = 1'b0,
		FRAME_CRC_BAD = 1'b1
	} frame_status_t;

	typedef struct packed {
		logic markers_ok;
		logic crc_ok;
	} verdict_t;

	// one byte of crc-16, polynomial 0x1021, msb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

[rtl/cdf_ifs.sv]
// valid/ready channel interfaces for received bytes and decoded frames
// no dependencies
`timescale 1ns / 1ps

interface cdf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface cdf_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] left_command;
	logic [7:0] right_command;
	logic [7:0] flag_bits;
	logic       frame_status;

	modport source(output valid, output left_command, output right_command,
		output flag_bits, output frame_status, input ready);
	modport sink(input valid, input left_command, input right_command,
		input flag_bits, input frame_status, output ready);
endinterface

[rtl/cdf_cell.sv]
// one window cell: holds a byte and the running crc of the sequence it opens
// depends on cdf_pkg for the crc byte step
`timescale 1ns / 1ps

module cdf_cell import cdf_pkg::*; #(
	parameter bit EXTEND = 1'b0
) (
	input  logic        clk,
	input  logic        shift_en,
	input  logic [7:0]  byte_in,
	input  logic [15:0] crc_in,
	input  logic [7:0]  ext_byte,
	output logic [7:0]  byte_out,
	output logic [15:0] crc_out
);

	logic [7:0]  byte_q;
	logic [15:0] crc_q;

	// young cells fold the arriving byte into the crc they carry forward
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
			crc_q  <= EXTEND ? crc16_byte(crc_in, ext_byte) : crc_in;
		end
	end

	assign byte_out = byte_q;
	assign crc_out  = crc_q;

endmodule

[rtl/cdf_judge.sv]
// frame check over a full window: marker, trailer and crc comparison
// depends on cdf_pkg for positions and the verdict type
`timescale 1ns / 1ps

module cdf_judge import cdf_pkg::*; (
	input  logic [FRAME_BYTES-1:0][7:0] window,
	input  logic [15:0]                 head_crc,
	input  logic [7:0]                  start_marker,
	input  logic [15:0]                 end_marker,
	output verdict_t                    verdict
);

	always_comb begin
		verdict.markers_ok = (window[POS_START] == start_marker) &&
			(window[POS_END_H] == end_marker[15:8]) &&
			(window[POS_END_L] == end_marker[7:0]);
		verdict.crc_ok = (head_crc == {window[POS_CRC_H], window[POS_CRC_L]});
	end

endmodule

[rtl/crc_checked_frame_deframer.sv]
// Frame deframer for a byte stream: a chain of eight byte cells forms a
// sliding window, the four youngest cells fold each arriving byte into a crc
// so the oldest cell always carries the crc-16 of the frame head. One byte is
// taken per clock cycle while input is not stalled. A window that fills is
// checked from registers once the output register is free, and a result with
// matching markers lands in the output register; input stalls only while a
// full window waits on an untaken result in the output register. The user
// must write markers over the cfg port only while no frame is in flight; the
// block does not enforce this. The one-bit index selects one of two registers.
// depends on cdf_pkg, cdf_ifs, cdf_cell, cdf_judge and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc_checked_frame_deframer import cdf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	cdf_rx_if.sink                rx,
	cdf_frame_if.source           frames,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [7:0]        start_marker_q;
	logic [15:0]       end_marker_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_eff;
	logic [FILL_W-1:0] fill_d;

	logic [FRAME_BYTES-1:0][7:0]  cell_byte;
	logic [FRAME_BYTES-1:0][15:0] cell_crc;

	verdict_t verdict;
	logic     rx_fire;
	logic     pending;
	logic     out_free;
	logic     do_check;
	logic     good_frame;
	logic     out_load;

	logic       out_valid_q;
	logic [7:0] left_q;
	logic [7:0] right_q;
	logic [7:0] flags_q;
	logic       status_q;

	// marker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RESET;
			end_marker_q   <= END_MARKER_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_MARKER: start_marker_q <= cfg_data[7:0];
				REG_END_MARKER:   end_marker_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// window cells, youngest at the top of the chain
	for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
		if (k == FRAME_BYTES - 1) begin : g_top
			cdf_cell #(.EXTEND(1'b1)) u_cell (
				.clk      (clk),
				.shift_en (rx_fire),
				.byte_in  (rx.rx_byte),
				.crc_in   (CRC_INIT),
				.ext_byte (rx.rx_byte),
				.byte_out (cell_byte[k]),
				.crc_out  (cell_crc[k])
			);
		end else begin : g_mid
			cdf_cell #(.EXTEND(k >= FRAME_BYTES - CRC_SPAN)) u_cell (
				.clk      (clk),
				.shift_en (rx_fire),
				.byte_in  (cell_byte[k+1]),
				.crc_in   (cell_crc[k+1]),
				.ext_byte (rx.rx_byte),
				.byte_out (cell_byte[k]),
				.crc_out  (cell_crc[k])
			);
		end
	end

	cdf_judge u_judge (
		.window       (cell_byte),
		.head_crc     (cell_crc[POS_START]),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.verdict      (verdict)
	);

	assign pending    = (fill_q == FILL_W'(FRAME_BYTES));
	assign out_free   = !out_valid_q || frames.ready;
	assign do_check   = pending && out_free;
	assign good_frame = verdict.markers_ok && verdict.crc_ok;
	assign out_load   = do_check && verdict.markers_ok;
	assign rx.ready   = !pending || out_free;
	assign rx_fire    = rx.valid && rx.ready;

	// a check empties the window or drops its oldest byte before the new transfer
	always_comb begin
		fill_eff = fill_q;
		if (do_check) begin
			fill_eff = good_frame ? '0 : FILL_W'(FRAME_BYTES - 1);
		end
		fill_d = rx_fire ? fill_eff + FILL_W'(1) : fill_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (frames.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_q   <= good_frame ? cell_byte[POS_LEFT]  : 8'h00;
			right_q  <= good_frame ? cell_byte[POS_RIGHT] : 8'h00;
			flags_q  <= good_frame ? cell_byte[POS_FLAGS] : 8'h00;
			status_q <= good_frame ? FRAME_GOOD : FRAME_CRC_BAD;
		end
	end

	assign frames.valid         = out_valid_q;
	assign frames.left_command  = left_q;
	assign frames.right_command = right_q;
	assign frames.flag_bits     = flags_q;
	assign frames.frame_status  = status_q;

	`ASSERT_NEXT(a_good_frame_clears, clk, arst_n, do_check && good_frame, fill_q <= FILL_W'(1), "good frame did not empty the window")
	`ASSERT_NEXT(a_blocked_check_waits, clk, arst_n, pending && !do_check, pending, "window check lost while output was blocked")
	`ASSERT_IMPL(a_result_from_check, clk, arst_n, $rose(out_valid_q), $past(do_check), "result appeared without a window check")

endmodule
